### rtl/core/spod_pkg.sv
// Shared constants, types and helpers for the set product sort/dedup block.
// No dependencies.
`default_nettype none
package spod_pkg;
    localparam int SET_CAP   = 8;
    localparam int TERM_BITS = 64;
    localparam int IDX_W     = $clog2(SET_CAP);
    localparam int CNT_W     = $clog2(SET_CAP + 1);
    localparam int DIST_W    = 7;

    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_RUN    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_EMIT
    } spod_state_t;

    function automatic logic [TERM_BITS-1:0] compare_mask(input logic [6:0] col_bits);
        logic [6:0] bits;
        logic [3:0] bytes;
        logic [TERM_BITS-1:0] m;
        bits = col_bits;
        if (bits == 7'd0)
        begin
            bits = 7'd1;
        end
        if (bits > 7'(TERM_BITS))
        begin
            bits = 7'(TERM_BITS);
        end
        bytes = 4'((bits + 7'd7) >> 3);
        for (int k = 0; k < TERM_BITS / 8; k++)
        begin
            m[k*8 +: 8] = (4'(k) < bytes) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction
endpackage
`default_nettype wire

### rtl/core/spod_cmp.sv
// Shared compare unit: decides whether a candidate replaces the running minimum.
// Depends on spod_pkg.
`default_nettype none
module spod_cmp
    import spod_pkg::*;
(
    input  wire logic [TERM_BITS-1:0] cand,
    input  wire logic [TERM_BITS-1:0] floor_val,
    input  wire logic                 have_floor,
    input  wire logic [TERM_BITS-1:0] best,
    input  wire logic                 found,
    output logic                      take
);
    always_comb
    begin
        take = (!have_floor || cand > floor_val) && (!found || cand < best);
    end
endmodule
`default_nettype wire

### rtl/core/set_product_or_sort_dedup.sv
// Top level: loads two term sets and emits the sorted distinct OR products.
// Depends on spod_pkg and spod_cmp.
//
// Usage:
//   start/busy command channel: a beat is taken when start is high and busy low.
//   kind 0/1 loads term_word into set A/B; loads beyond eight terms
//   are dropped and flagged. kind 2 runs the merge; kind 3 is ignored.
//   A run scans all P = |A| * |B| pairs with one comparator: D + 1 scans to count
//   the D distinct products, then D scans to emit them in order.
//   Each result shows in the cycle after its scan.
//   An empty set gives one result, set_empty high, on the next cycle.
//   Each result is shown for one cycle under result_valid; the receiver cannot
//   stall. cfg channel writes column_bits while idle (cfg_ready = !busy).
//   Reset clears both sets, the overflow flag and returns column_bits to 64.
`default_nettype none
module set_product_or_sort_dedup
    import spod_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           kind,
    input  wire logic [TERM_BITS-1:0] term_word,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [6:0]           cfg_data,
    output logic                      result_valid,
    output logic [TERM_BITS-1:0]      product_word,
    output logic                      last_product,
    output logic [DIST_W-1:0]         distinct_count,
    output logic                      set_empty,
    output logic                      load_overflow
);
    spod_state_t state_reg, state_next;
    logic [6:0] col_reg;
    logic [TERM_BITS-1:0] a_reg [SET_CAP];
    logic [TERM_BITS-1:0] b_reg [SET_CAP];
    logic [CNT_W-1:0] cnt_a_reg, cnt_b_reg;
    logic ovf_reg;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [TERM_BITS-1:0] best_reg, best_next, floor_reg, floor_next;
    logic found_reg, found_next, have_reg, have_next;
    logic [DIST_W-1:0] dist_reg, dist_next, done_reg, done_next;
    logic rv_next, last_next, empty_next, clear_sets;
    logic [TERM_BITS-1:0] pw_next, cand, best_upd;
    logic found_upd, take, scan_end, accept;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;
    assign cand      = (a_reg[i_reg] | b_reg[j_reg]) & compare_mask(col_reg);
    assign scan_end  = ({1'b0, i_reg} == cnt_a_reg - 1'b1) && ({1'b0, j_reg} == cnt_b_reg - 1'b1);

    spod_cmp u_cmp (
        .cand       (cand),
        .floor_val  (floor_reg),
        .have_floor (have_reg),
        .best       (best_reg),
        .found      (found_reg),
        .take       (take)
    );

    assign best_upd  = take ? cand : best_reg;
    assign found_upd = found_reg || take;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        best_next  = best_upd;
        found_next = found_upd;
        floor_next = floor_reg;
        have_next  = have_reg;
        dist_next  = dist_reg;
        done_next  = done_reg;
        rv_next    = 1'b0;
        pw_next    = best_upd;
        last_next  = 1'b0;
        empty_next = 1'b0;
        clear_sets = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                best_next  = best_reg;
                found_next = 1'b0;
                if (accept && kind == KIND_RUN)
                begin
                    i_next    = '0;
                    j_next    = '0;
                    have_next = 1'b0;
                    dist_next = '0;
                    done_next = '0;
                    if (cnt_a_reg == '0 || cnt_b_reg == '0)
                    begin
                        rv_next    = 1'b1;
                        pw_next    = '0;
                        last_next  = 1'b1;
                        empty_next = 1'b1;
                        clear_sets = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_COUNT;
                    end
                end
            end
            ST_COUNT, ST_EMIT:
            begin
                if (!scan_end)
                begin
                    if ({1'b0, j_reg} == cnt_b_reg - 1'b1)
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    i_next     = '0;
                    j_next     = '0;
                    found_next = 1'b0;
                    if (state_reg == ST_COUNT)
                    begin
                        if (found_upd)
                        begin
                            floor_next = best_upd;
                            have_next  = 1'b1;
                            dist_next  = dist_reg + 1'b1;
                        end
                        else
                        begin
                            have_next  = 1'b0;
                            state_next = ST_EMIT;
                        end
                    end
                    else
                    begin
                        rv_next    = 1'b1;
                        floor_next = best_upd;
                        have_next  = 1'b1;
                        done_next  = done_reg + 1'b1;
                        if (done_reg + 1'b1 == dist_reg)
                        begin
                            last_next  = 1'b1;
                            clear_sets = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            col_reg      <= 7'(TERM_BITS);
            cnt_a_reg    <= '0;
            cnt_b_reg    <= '0;
            ovf_reg      <= 1'b0;
            found_reg    <= 1'b0;
            have_reg     <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            found_reg    <= found_next;
            have_reg     <= have_next;
            result_valid <= rv_next;
            if (cfg_valid && cfg_ready)
            begin
                col_reg <= cfg_data;
            end
            if (accept && kind == KIND_LOAD_A)
            begin
                if (cnt_a_reg < CNT_W'(SET_CAP))
                begin
                    cnt_a_reg <= cnt_a_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (accept && kind == KIND_LOAD_B)
            begin
                if (cnt_b_reg < CNT_W'(SET_CAP))
                begin
                    cnt_b_reg <= cnt_b_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (clear_sets)
            begin
                cnt_a_reg <= '0;
                cnt_b_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        best_reg  <= best_next;
        floor_reg <= floor_next;
        dist_reg  <= dist_next;
        done_reg  <= done_next;
        if (rv_next)
        begin
            product_word   <= pw_next;
            last_product   <= last_next;
            distinct_count <= empty_next ? '0 : dist_reg;
            set_empty      <= empty_next;
            load_overflow  <= ovf_reg;
        end
        if (accept && kind == KIND_LOAD_A && cnt_a_reg < CNT_W'(SET_CAP))
        begin
            a_reg[cnt_a_reg[IDX_W-1:0]] <= term_word;
        end
        if (accept && kind == KIND_LOAD_B && cnt_b_reg < CNT_W'(SET_CAP))
        begin
            b_reg[cnt_b_reg[IDX_W-1:0]] <= term_word;
        end
    end

    a_strobe_busy_or_run: assert property (@(posedge clk) disable iff (!rst_n)
        rv_next |-> (busy || (accept && kind == KIND_RUN)))
        else $error("result outside a run");
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && set_empty) |-> last_product)
        else $error("empty result not marked last");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_product) |-> !busy)
        else $error("block busy after last result");
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (done_reg < dist_reg))
        else $error("emitted more than counted");
endmodule
`default_nettype wire
